>>> design/dirty_tile_region_tracker_core_assert.svh
// Assertion macros of the dirty tile region tracker core.
`ifndef DIRTY_TILE_REGION_TRACKER_CORE_ASSERT_SVH
`define DIRTY_TILE_REGION_TRACKER_CORE_ASSERT_SVH

// Checked only while the block is out of reset.
`define DTRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DTRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dtrt_pkg.sv
// Shared constants, payload types and helper functions of the dirty tile tracker.
package dtrt_pkg;

  localparam int TILE_PIXELS  = 8;
  localparam int TILE_COLUMNS = 30;
  localparam int TILE_ROWS    = 30;

  localparam int MASK_W = 32;
  localparam int CIDX_W = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
  localparam int COL_W  = $clog2(TILE_COLUMNS + 1);
  localparam int ROW_AW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int ROW_W  = $clog2(TILE_ROWS + 1);

  localparam int SCREEN_W = TILE_COLUMNS * TILE_PIXELS;
  localparam int SCREEN_H = TILE_ROWS * TILE_PIXELS;
  localparam logic signed [15:0] SCREEN_W_S   = 16'(SCREEN_W);
  localparam logic signed [15:0] SCREEN_H_S   = 16'(SCREEN_H);
  localparam logic signed [15:0] SCREEN_W_MAX = 16'(SCREEN_W - 1);
  localparam logic signed [15:0] SCREEN_H_MAX = 16'(SCREEN_H - 1);

  localparam logic [MASK_W-1:0] MASK_ONES  = '1;
  localparam logic [MASK_W-1:0] VALID_COLS = MASK_W'((64'd1 << TILE_COLUMNS) - 64'd1);

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_MARK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NEXT    = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [15:0]  rect_left;
    logic signed [15:0]  rect_top;
    logic signed [15:0]  rect_right;
    logic signed [15:0]  rect_bottom;
  } req_t;

  typedef struct packed {
    logic        region_found;
    logic [7:0]  region_x;
    logic [7:0]  region_y;
    logic [7:0]  region_width;
    logic [7:0]  region_height;
    logic [9:0]  dirty_count;
  } rsp_t;

  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [MASK_W-1:0] wr_data;
  } ram_req_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [4:0] lowest_index(logic [MASK_W-1:0] x);
    logic [MASK_W-1:0] low;
    logic [4:0]        idx;
    low = x & (~x + MASK_W'(1));
    idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (low[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

  // Population count, summed as four byte counts.
  function automatic logic [5:0] popcount32(logic [MASK_W-1:0] x);
    logic [3:0] g [4];
    for (int k = 0; k < 4; k++) begin
      g[k] = '0;
      for (int j = 0; j < 8; j++) begin
        g[k] = g[k] + 4'(x[k*8+j]);
      end
    end
    return 6'(g[0]) + 6'(g[1]) + 6'(g[2]) + 6'(g[3]);
  endfunction

endpackage

>>> design/dirty_tile_region_tracker_core.sv
// Top level of the dirty tile region tracker: request decode, mark and scan sequencer.
//
// Use: one request in, one response out, both valid/ready channels.
// Each request carries a mode: clear the map, mark a pixel rectangle,
// restart the scan, or fetch the next dirty region. Every request gives
// exactly one response, holding the region (zero when none) and the
// number of dirty tiles after the request.
// Requests are served one at a time; req_ready is high while idle.
// Clear and restart go from acceptance straight to the response state.
// A mark reads and rewrites one tile row per cycle through the mask
// memory, overlapping the read of a row with the write of the previous one.
// A region fetch evaluates each row read from the memory on arrival,
// moving down row by row until a dirty run is found, then extends the
// region downward over the following rows that match it exactly.
// Reset clears the map (by per-row valid bits), the count and the scan
// position. When the receiver stalls, the finished response is held in
// the output register; a following request is still accepted and worked,
// but its response waits and req_ready stays low meanwhile.
module dirty_tile_region_tracker_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dtrt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dtrt_pkg::rsp_t rsp
);

`include "dirty_tile_region_tracker_core_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_PREV, S_ROW, S_RUN, S_EXT, S_DONE
  } state_t;

  state_t state;

  dtrt_pkg::ram_req_t              ram_req;
  logic [dtrt_pkg::MASK_W-1:0]     rd_mask;

  logic [9:0]                      dirty_total;
  logic [dtrt_pkg::ROW_W-1:0]      scan_row;
  logic [dtrt_pkg::CIDX_W-1:0]     scan_column;

  // Mark pipeline.
  logic [dtrt_pkg::MASK_W-1:0]     cmask;
  logic [dtrt_pkg::ROW_AW-1:0]     last_row;
  logic [dtrt_pkg::ROW_AW-1:0]     issue_row;
  logic                            mk_issue;
  logic                            pend;
  logic [dtrt_pkg::ROW_AW-1:0]     pend_row;

  // Scan working registers.
  logic [dtrt_pkg::MASK_W-1:0]     prev_mask;
  logic [dtrt_pkg::MASK_W-1:0]     cur_mask;
  logic [dtrt_pkg::CIDX_W-1:0]     first_col;
  logic [dtrt_pkg::COL_W-1:0]      end_col;
  logic [dtrt_pkg::ROW_AW-1:0]     reg_row;
  logic [dtrt_pkg::ROW_W-1:0]      er;
  logic                            res_found;

  logic                            accept;
  logic                            rect_bad;
  logic signed [15:0]              cl_left, cl_top, cl_right, cl_bottom;
  logic [dtrt_pkg::CIDX_W-1:0]     c0, c1;
  logic [dtrt_pkg::ROW_AW-1:0]     r0, r1;
  logic [4:0]                      hi_shift;
  logic [dtrt_pkg::MASK_W-1:0]     cmask_new;
  logic [dtrt_pkg::ROW_W-1:0]      scan_row_dec, scan_row_inc, er_inc;
  logic [dtrt_pkg::MASK_W-1:0]     row_masked;
  logic [4:0]                      low_col;
  logic                            row_skip;
  logic                            row_advance;
  logic [dtrt_pkg::MASK_W-1:0]     run_z;
  logic [dtrt_pkg::COL_W-1:0]      run_end;
  logic [dtrt_pkg::COL_W-1:0]      run_len;
  logic [dtrt_pkg::ROW_W-1:0]      run_ht;
  logic [5:0]                      new_bits;
  dtrt_pkg::rsp_t                  rsp_next;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Rectangle decode: reject, clamp, then convert to tile bounds.
  always_comb begin
    rect_bad = (req.rect_left > req.rect_right) || (req.rect_top > req.rect_bottom) ||
               (req.rect_right < 16'sd0) || (req.rect_bottom < 16'sd0) ||
               (req.rect_left >= dtrt_pkg::SCREEN_W_S) ||
               (req.rect_top >= dtrt_pkg::SCREEN_H_S);
    cl_left   = (req.rect_left < 16'sd0) ? 16'sd0 : req.rect_left;
    cl_top    = (req.rect_top < 16'sd0) ? 16'sd0 : req.rect_top;
    cl_right  = (req.rect_right > dtrt_pkg::SCREEN_W_MAX) ? dtrt_pkg::SCREEN_W_MAX
                                                          : req.rect_right;
    cl_bottom = (req.rect_bottom > dtrt_pkg::SCREEN_H_MAX) ? dtrt_pkg::SCREEN_H_MAX
                                                           : req.rect_bottom;
    c0 = dtrt_pkg::CIDX_W'($unsigned(cl_left) / dtrt_pkg::TILE_PIXELS);
    c1 = dtrt_pkg::CIDX_W'($unsigned(cl_right) / dtrt_pkg::TILE_PIXELS);
    r0 = dtrt_pkg::ROW_AW'($unsigned(cl_top) / dtrt_pkg::TILE_PIXELS);
    r1 = dtrt_pkg::ROW_AW'($unsigned(cl_bottom) / dtrt_pkg::TILE_PIXELS);
    hi_shift  = 5'(dtrt_pkg::MASK_W - 1) - 5'(c1);
    cmask_new = (dtrt_pkg::MASK_ONES << c0) & (dtrt_pkg::MASK_ONES >> hi_shift);
  end

  // Scan evaluation of the row mask arriving from memory.
  always_comb begin
    scan_row_dec = scan_row - dtrt_pkg::ROW_W'(1);
    scan_row_inc = scan_row + dtrt_pkg::ROW_W'(1);
    er_inc       = er + dtrt_pkg::ROW_W'(1);
    row_masked   = rd_mask & dtrt_pkg::VALID_COLS & (dtrt_pkg::MASK_ONES << scan_column);
    low_col      = dtrt_pkg::lowest_index(row_masked);
    row_skip     = (scan_column == '0) && (scan_row != '0) && (rd_mask == prev_mask);
    row_advance  = row_skip || (row_masked == '0);
    run_z        = ~cur_mask & dtrt_pkg::VALID_COLS & (dtrt_pkg::MASK_ONES << first_col);
    run_end      = (run_z == '0) ? dtrt_pkg::COL_W'(dtrt_pkg::TILE_COLUMNS)
                                 : dtrt_pkg::COL_W'(dtrt_pkg::lowest_index(run_z));
    new_bits     = dtrt_pkg::popcount32(cmask & ~rd_mask);
  end

  // Memory port control.
  always_comb begin
    ram_req         = '0;
    ram_req.wr_addr = pend_row;
    ram_req.wr_data = rd_mask | cmask;
    unique case (state)
      S_IDLE: begin
        if (accept && req.mode == dtrt_pkg::MODE_CLEAR) begin
          ram_req.clear = 1'b1;
        end
        if (accept && req.mode == dtrt_pkg::MODE_NEXT &&
            scan_row < dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS)) begin
          ram_req.rd_en = 1'b1;
          if (scan_column == '0 && scan_row != '0) begin
            ram_req.rd_addr = scan_row_dec[dtrt_pkg::ROW_AW-1:0];
          end else begin
            ram_req.rd_addr = scan_row[dtrt_pkg::ROW_AW-1:0];
          end
        end
      end
      S_MARK: begin
        ram_req.rd_en   = mk_issue;
        ram_req.rd_addr = issue_row;
        ram_req.wr_en   = pend;
      end
      S_PREV: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = scan_row[dtrt_pkg::ROW_AW-1:0];
      end
      S_ROW: begin
        ram_req.rd_en   = row_advance &&
                          (scan_row != dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS - 1));
        ram_req.rd_addr = scan_row_inc[dtrt_pkg::ROW_AW-1:0];
      end
      S_RUN: begin
        ram_req.rd_en   = (scan_row != dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS - 1));
        ram_req.rd_addr = scan_row_inc[dtrt_pkg::ROW_AW-1:0];
      end
      S_EXT: begin
        ram_req.rd_en   = (rd_mask == cur_mask) &&
                          (er_inc < dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS));
        ram_req.rd_addr = er_inc[dtrt_pkg::ROW_AW-1:0];
      end
      S_DONE: begin
        ram_req.rd_en = 1'b0;
      end
      default: begin
        ram_req.rd_en = 1'b0;
      end
    endcase
  end

  // Response assembly from the scan registers.
  always_comb begin
    run_len  = end_col - dtrt_pkg::COL_W'(first_col);
    run_ht   = er - dtrt_pkg::ROW_W'(reg_row);
    rsp_next = '0;
    rsp_next.dirty_count = dirty_total;
    if (res_found) begin
      rsp_next.region_found  = 1'b1;
      rsp_next.region_x      = 8'(first_col * dtrt_pkg::TILE_PIXELS);
      rsp_next.region_y      = 8'(reg_row * dtrt_pkg::TILE_PIXELS);
      rsp_next.region_width  = 8'(run_len * dtrt_pkg::TILE_PIXELS);
      rsp_next.region_height = 8'(run_ht * dtrt_pkg::TILE_PIXELS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      dirty_total <= '0;
      scan_row    <= '0;
      scan_column <= '0;
      mk_issue    <= 1'b0;
      pend        <= 1'b0;
      res_found   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_found <= 1'b0;
            unique case (req.mode)
              dtrt_pkg::MODE_CLEAR: begin
                dirty_total <= '0;
                scan_row    <= '0;
                scan_column <= '0;
                state       <= S_DONE;
              end
              dtrt_pkg::MODE_MARK: begin
                if (rect_bad) begin
                  state <= S_DONE;
                end else begin
                  cmask     <= cmask_new;
                  issue_row <= r0;
                  last_row  <= r1;
                  mk_issue  <= 1'b1;
                  pend      <= 1'b0;
                  state     <= S_MARK;
                end
              end
              dtrt_pkg::MODE_RESTART: begin
                scan_row    <= '0;
                scan_column <= '0;
                state       <= S_DONE;
              end
              dtrt_pkg::MODE_NEXT: begin
                if (scan_row >= dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS)) begin
                  state <= S_DONE;
                end else if (scan_column == '0 && scan_row != '0) begin
                  state <= S_PREV;
                end else begin
                  state <= S_ROW;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MARK: begin
          // Row issue_row is being read while row pend_row is written back.
          pend     <= mk_issue;
          pend_row <= issue_row;
          if (mk_issue) begin
            if (issue_row == last_row) begin
              mk_issue <= 1'b0;
            end else begin
              issue_row <= issue_row + dtrt_pkg::ROW_AW'(1);
            end
          end
          if (pend) begin
            dirty_total <= dirty_total + 10'(new_bits);
            if (pend_row == last_row) begin
              state <= S_DONE;
            end
          end
        end
        S_PREV: begin
          prev_mask <= rd_mask;
          state     <= S_ROW;
        end
        S_ROW: begin
          if (row_advance) begin
            prev_mask   <= rd_mask;
            scan_row    <= scan_row_inc;
            scan_column <= '0;
            if (scan_row == dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS - 1)) begin
              state <= S_DONE;
            end
          end else begin
            cur_mask  <= rd_mask;
            first_col <= low_col[dtrt_pkg::CIDX_W-1:0];
            reg_row   <= scan_row[dtrt_pkg::ROW_AW-1:0];
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          end_col   <= run_end;
          er        <= scan_row_inc;
          res_found <= 1'b1;
          if (run_end >= dtrt_pkg::COL_W'(dtrt_pkg::TILE_COLUMNS)) begin
            scan_row    <= scan_row_inc;
            scan_column <= '0;
          end else begin
            scan_column <= run_end[dtrt_pkg::CIDX_W-1:0];
          end
          if (scan_row == dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS - 1)) begin
            state <= S_DONE;
          end else begin
            state <= S_EXT;
          end
        end
        S_EXT: begin
          // Extend the region downward while the rows match exactly.
          if (rd_mask == cur_mask) begin
            er <= er_inc;
            if (er_inc >= dtrt_pkg::ROW_W'(dtrt_pkg::TILE_ROWS)) begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dtrt_mask_ram u_mask_ram (
    .clk     (clk),
    .rst     (rst),
    .ram_req (ram_req),
    .rd_mask (rd_mask)
  );

  `DTRT_ASSERT(a_wr_only_mark, ram_req.wr_en |-> (state == S_MARK), "mask write outside marking")
  `DTRT_ASSERT(a_no_rw_same_row, (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr), "read and write hit one row")
  `DTRT_ASSERT(a_count_hold, (state != S_MARK && !(req_valid && req_ready)) |=> $stable(dirty_total), "dirty count changed outside mark or clear")
  `DTRT_ASSERT(a_scan_col_range, (state == S_IDLE) |-> (scan_column < dtrt_pkg::TILE_COLUMNS), "scan column out of range")
  `DTRT_ASSERT_ALWAYS(a_reset_idle, rst |=> (!rsp_valid && state == S_IDLE), "block not idle after reset")

endmodule

>>> design/dtrt_mask_ram.sv
// Row mask memory with one read and one write port and per-row valid bits.
module dtrt_mask_ram (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dtrt_pkg::ram_req_t                     ram_req,
  output logic [dtrt_pkg::MASK_W-1:0]            rd_mask
);

  logic [dtrt_pkg::MASK_W-1:0] mem [dtrt_pkg::TILE_ROWS];
  logic [dtrt_pkg::TILE_ROWS-1:0] row_valid;
  logic [dtrt_pkg::MASK_W-1:0] rd_data;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (ram_req.wr_en) begin
      mem[ram_req.wr_addr] <= ram_req.wr_data;
    end
    if (ram_req.rd_en) begin
      rd_data <= mem[ram_req.rd_addr];
    end
  end

  // A row that was never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || ram_req.clear) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (ram_req.wr_en) begin
        row_valid[ram_req.wr_addr] <= 1'b1;
      end
      if (ram_req.rd_en) begin
        rd_vld <= row_valid[ram_req.rd_addr];
      end
    end
  end

  assign rd_mask = rd_vld ? rd_data : '0;

endmodule
